[rtl/edt_pkg.sv]
// ----------------------------------------------------------------------------
// edt_pkg
// Shared types, geometry constants and the channel compare used by the 3x3
// edge detector.
// ----------------------------------------------------------------------------
package edt_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	localparam int CHAN_W  = 8;
	localparam int N_CHAN  = 3;
	localparam int PIXEL_W = CHAN_W * N_CHAN;
	localparam int THR_W   = 8;
	localparam int DIM_W   = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DIM_W;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

	// Working width for geometry arithmetic: holds any register value plus two
	// and any clamped dimension plus two.
	localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int GEO_NEED = $clog2(MAX_DIM + 3);
	localparam int GEO_W = (GEO_NEED > DIM_W + 1) ? GEO_NEED : DIM_W + 1;

	localparam logic [THR_W-1:0] THRESHOLD_RST    = THR_W'(10);
	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(480);

	typedef logic [PIXEL_W-1:0] pixel_t;
	typedef logic [THR_W-1:0]   thr_t;
	typedef logic [DIM_W-1:0]   dim_t;
	typedef logic [GEO_W-1:0]   geo_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD    = 2'd0,
		CFG_FRAME_WIDTH  = 2'd1,
		CFG_FRAME_HEIGHT = 2'd2
	} cfg_idx_t;

	// Per-item control carried from the count stage to the window stage.
	typedef struct packed {
		logic produce;
		logic last;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
	} win_ctrl_t;

	// True when any channel of b differs from a by more than thr.
	function automatic logic px_exceeds(pixel_t a, pixel_t b, thr_t thr);
		logic [CHAN_W-1:0] x;
		logic [CHAN_W-1:0] y;
		logic [CHAN_W-1:0] d;
		logic              hit;
		hit = 1'b0;
		for (int ch = 0; ch < N_CHAN; ch++) begin
			x = a[ch*CHAN_W +: CHAN_W];
			y = b[ch*CHAN_W +: CHAN_W];
			d = (x > y) ? x - y : y - x;
			hit = hit | (d > thr);
		end
		return hit;
	endfunction

endpackage

[rtl/edt_ram.sv]
// ----------------------------------------------------------------------------
// edt_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module edt_ram #(
	parameter  int WIDTH  = 8,
	parameter  int DEPTH  = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/edge_detect_3x3_threshold.sv]
// ----------------------------------------------------------------------------
// edge_detect_3x3_threshold
// Streaming 3x3 edge marker over 24-bit RGB frames in raster order.
// ----------------------------------------------------------------------------
// Takes one item per clock unless a stalled result holds the window stage.
// Each item reads and writes back one entry of a single line store (upper
// and middle rows side by side, registered read) and shifts the 3x3 window;
// a pixel's result comes out once the item one row plus one pixel later has
// been taken, so the host follows each frame with frame_width + 1 flush
// items. The line store has no reset and no clearing pass: entries outside
// the frame are never compared. Writing frame_width or frame_height
// restarts the frame; write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module edge_detect_3x3_threshold (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [edt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [edt_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input items
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  edt_pkg::pixel_t                     pixel_rgb,
	// results
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                is_edge,
	output logic                                last_of_frame
);

	import edt_pkg::*;

	localparam int LINE_W = 2 * PIXEL_W;

	// configuration
	thr_t threshold_q;
	dim_t frame_width_q;
	dim_t frame_height_q;
	logic cfg_wr;

	// raster position
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// count stage
	geo_t      w_g, h_g, fw_g, fh_g, col_g, row_g, c_e, col_inc, col_n, row_n;
	logic      case_a, case_b;
	win_ctrl_t ctrl_s0;
	pixel_t    px_s0;
	logic      accept;
	logic [COL_W-1:0] rd_addr;

	// window stage
	logic             s1_vld_q;
	logic             s1_fire;
	win_ctrl_t        ctrl_s1;
	pixel_t           px_s1;
	logic [COL_W-1:0] col_s1;
	logic             fwd_s1;
	logic [LINE_W-1:0] fwd_data_s1;
	logic [LINE_W-1:0] ram_rd;
	logic [LINE_W-1:0] line_rd;
	logic [LINE_W-1:0] wr_data;
	pixel_t           top_px, mid_px;

	pixel_t win_q [3][2];
	pixel_t win_n [3][3];
	logic [2:0] row_ok, col_ok;
	logic       edge_hit;

	// result register
	logic out_valid_q;
	logic is_edge_q;
	logic last_q;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= THRESHOLD_RST;
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_THRESHOLD:    threshold_q    <= cfg_data[THR_W-1:0];
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[DIM_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- count stage ----------------
	always_comb begin
		fw_g = GEO_W'(frame_width_q);
		fh_g = GEO_W'(frame_height_q);
		if (fw_g == '0) begin
			w_g = GEO_W'(1);
		end else if (fw_g > GEO_W'(MAX_WIDTH)) begin
			w_g = GEO_W'(MAX_WIDTH);
		end else begin
			w_g = fw_g;
		end
		if (fh_g == '0) begin
			h_g = GEO_W'(1);
		end else if (fh_g > GEO_W'(MAX_HEIGHT)) begin
			h_g = GEO_W'(MAX_HEIGHT);
		end else begin
			h_g = fh_g;
		end

		col_g = GEO_W'(col_q);
		row_g = GEO_W'(row_q);
		c_e   = (col_g >= w_g) ? '0 : col_g;

		// case A: first column of a row closes the last pixel of row r-2
		// case B: any later column closes pixel (r-1, c-1)
		case_a = (c_e == '0) && (row_g >= GEO_W'(2)) && (row_g < h_g + GEO_W'(2));
		case_b = (c_e != '0) && (row_g >= GEO_W'(1)) && (row_g <= h_g);

		ctrl_s0.produce  = case_a | case_b;
		ctrl_s0.last     = case_a && (row_g == h_g + GEO_W'(1));
		ctrl_s0.top_ok   = case_a ? (row_g >= GEO_W'(3)) : (row_g >= GEO_W'(2));
		ctrl_s0.bot_ok   = case_a ? (row_g < h_g + GEO_W'(1)) : (row_g < h_g);
		ctrl_s0.left_ok  = case_a ? (w_g >= GEO_W'(2)) : (c_e >= GEO_W'(2));
		ctrl_s0.right_ok = ~case_a;

		col_inc = c_e + GEO_W'(1);
		if (ctrl_s0.last) begin
			col_n = '0;
			row_n = '0;
		end else if (col_inc >= w_g) begin
			col_n = '0;
			row_n = (row_g < h_g + GEO_W'(1)) ? row_g + GEO_W'(1) : row_g;
		end else begin
			col_n = col_inc;
			row_n = row_g;
		end

		rd_addr = c_e[COL_W-1:0];
		px_s0   = kind ? '0 : pixel_rgb;
	end

	assign s1_fire  = s1_vld_q & (~ctrl_s1.produce | ~out_valid_q | ~out_stall);
	assign in_stall = s1_vld_q & ~s1_fire;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr && (cfg_index == CFG_FRAME_WIDTH ||
				cfg_index == CFG_FRAME_HEIGHT)) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_n[COL_W-1:0];
			row_q <= row_n[ROW_W-1:0];
		end
	end

	// ---------------- line store ----------------
	edt_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (s1_fire),
		.wr_addr (col_s1),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (accept) begin
			s1_vld_q <= 1'b1;
			// write-back to the entry being read in the same cycle: forward it
			fwd_s1   <= s1_fire && (col_s1 == rd_addr);
		end else if (s1_fire) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1     <= ctrl_s0;
			px_s1       <= px_s0;
			col_s1      <= rd_addr;
			fwd_data_s1 <= wr_data;
		end
	end

	// ---------------- window stage ----------------
	always_comb begin
		line_rd = fwd_s1 ? fwd_data_s1 : ram_rd;
		top_px  = line_rd[LINE_W-1:PIXEL_W];
		mid_px  = line_rd[PIXEL_W-1:0];
		wr_data = {mid_px, px_s1};

		for (int r = 0; r < 3; r++) begin
			win_n[r][0] = win_q[r][0];
			win_n[r][1] = win_q[r][1];
		end
		win_n[0][2] = top_px;
		win_n[1][2] = mid_px;
		win_n[2][2] = px_s1;

		// centre sits in the middle of the shifted window
		row_ok = {ctrl_s1.bot_ok, 1'b1, ctrl_s1.top_ok};
		col_ok = {ctrl_s1.right_ok, 1'b1, ctrl_s1.left_ok};

		edge_hit = 1'b0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				edge_hit = edge_hit | (row_ok[r] & col_ok[c] &
					px_exceeds(win_n[1][1], win_n[r][c], threshold_q));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= '0;
				win_q[r][1] <= '0;
			end
		end else if (s1_fire) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_n[r][1];
				win_q[r][1] <= win_n[r][2];
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && ctrl_s1.produce) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && ctrl_s1.produce) begin
			is_edge_q <= edge_hit;
			last_q    <= ctrl_s1.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_edge       = is_edge_q;
	assign last_of_frame = last_q;

endmodule

[sim/tb_edge_detect_3x3_threshold.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edge_detect_3x3_threshold
// Self-checking bench for the streaming 3x3 edge marker. A local model of the
// line stores, window and raster counters predicts each edge mark as beats are
// taken. Results are compared in order, field by field. Frames run under
// directed and random geometry and threshold settings, with bursts of valid
// gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_edge_detect_3x3_threshold;
	import edt_pkg::*;

	localparam int   CLK_HALF     = 10;
	localparam int   DRAIN_CYCLES = 8;
	localparam int   CYCLE_LIMIT  = 2000000;
	localparam int   RANDOM_ITEMS = 230;
	localparam logic KIND_PIXEL   = 1'b0;
	localparam logic KIND_FLUSH   = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		logic is_edge;
		logic last;
	} edge_mark_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	dim_t                 cfg_data      = '0;
	logic                 in_valid      = 1'b0;
	logic                 in_stall;
	logic                 kind          = KIND_PIXEL;
	pixel_t               pixel_rgb     = '0;
	logic                 out_valid;
	logic                 out_stall     = 1'b0;
	logic                 is_edge;
	logic                 last_of_frame;

	// model state
	pixel_t     upper_row [MAX_WIDTH];
	pixel_t     middle_row [MAX_WIDTH];
	pixel_t     win [9];
	int         col_pos    = 0;
	int         row_pos    = 0;
	thr_t       thr_reg    = THRESHOLD_RST;
	dim_t       width_reg  = FRAME_WIDTH_RST;
	dim_t       height_reg = FRAME_HEIGHT_RST;
	edge_mark_t pending_marks [$];
	edge_mark_t oldest_mark;

	int n_errors    = 0;
	int n_checked   = 0;
	int n_frames    = 0;
	int n_items     = 0;
	int n_flush     = 0;
	int n_geometry  = 0;
	int gap_pct     = 0;
	int stall_pct   = 0;
	bit quiet       = 1'b0;
	int stall_left  = 0;
	int cycle_count = 0;

	edge_detect_3x3_threshold u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.pixel_rgb     (pixel_rgb),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.is_edge       (is_edge),
		.last_of_frame (last_of_frame)
	);

	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d marks still outstanding", $time, pending_marks.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
			out_stall  <= 1'b1;
			stall_left = $urandom_range(1, 18) - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_marks.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual is_edge=%0b last_of_frame=%0b",
					$time, is_edge, last_of_frame);
				n_errors++;
			end else begin
				oldest_mark = pending_marks.pop_front();
				n_checked++;
				if (oldest_mark.last)
					n_frames++;
				if (is_edge !== oldest_mark.is_edge) begin
					$display("%0t: is_edge mismatch: expected %0b actual %0b",
						$time, oldest_mark.is_edge, is_edge);
					n_errors++;
				end
				if (last_of_frame !== oldest_mark.last) begin
					$display("%0t: last_of_frame mismatch: expected %0b actual %0b",
						$time, oldest_mark.last, last_of_frame);
					n_errors++;
				end
			end
		end
	end

	function automatic int clamp_dim(dim_t v, int maxv);
		if (v == 0)
			return 1;
		if (int'(v) > maxv)
			return maxv;
		return int'(v);
	endfunction

	// k is the window column holding the centre pixel at row pr, column pc
	function automatic bit centre_is_edge(int k, int pr, int pc, int w, int h);
		pixel_t            centre;
		pixel_t            nb;
		logic [CHAN_W-1:0] a;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] d;
		centre = win[3 + k];
		for (int dr = -1; dr <= 1; dr++) begin
			if (pr + dr < 0 || pr + dr >= h)
				continue;
			for (int dc = -1; dc <= 1; dc++) begin
				if (k + dc < 0 || k + dc > 2 || pc + dc < 0 || pc + dc >= w)
					continue;
				nb = win[(dr + 1) * 3 + k + dc];
				for (int ch = 0; ch < N_CHAN; ch++) begin
					a = centre[ch*CHAN_W +: CHAN_W];
					b = nb[ch*CHAN_W +: CHAN_W];
					d = (a > b) ? a - b : b - a;
					if (d > thr_reg)
						return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	task automatic compute_edge_mark(logic k, pixel_t px_in);
		int         w;
		int         h;
		int         c;
		int         r;
		pixel_t     px;
		pixel_t     top;
		pixel_t     mid;
		bit         produced;
		bit         hit;
		bit         last;
		edge_mark_t mark;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		c = col_pos;
		r = row_pos;
		px = (k == KIND_FLUSH) ? '0 : px_in;
		produced = 1'b0;
		hit = 1'b0;
		last = 1'b0;
		n_items++;
		if (k == KIND_FLUSH)
			n_flush++;
		if (c >= w)
			c = 0;
		// row start: close the previous row's rightmost pixel before the shift
		if (c == 0 && r >= 2 && r - 2 < h) begin
			hit = centre_is_edge(2, r - 2, w - 1, w, h);
			produced = 1'b1;
			last = (r - 2 == h - 1);
		end
		top = upper_row[c];
		mid = middle_row[c];
		upper_row[c] = mid;
		middle_row[c] = px;
		win[0] = win[1]; win[1] = win[2]; win[2] = top;
		win[3] = win[4]; win[4] = win[5]; win[5] = mid;
		win[6] = win[7]; win[7] = win[8]; win[8] = px;
		if (c >= 1 && r >= 1 && r - 1 < h) begin
			hit = centre_is_edge(1, r - 1, c - 1, w, h);
			produced = 1'b1;
			last = (r - 1 == h - 1) && (c - 1 == w - 1);
		end
		if (last) begin
			c = 0;
			r = 0;
		end else begin
			c++;
			if (c >= w) begin
				c = 0;
				if (r < h + 1)
					r++;
			end
		end
		col_pos = c;
		row_pos = r;
		if (produced) begin
			mark.is_edge = hit;
			mark.last = last;
			pending_marks.push_back(mark);
		end
	endtask

	task automatic send_item(logic k, pixel_t px);
		int gap;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		pixel_rgb <= px;
		do @(posedge clk); while (in_stall);
		compute_edge_mark(k, px);
	endtask

	task automatic send_flush(int n);
		repeat (n) send_item(KIND_FLUSH, pixel_t'($urandom));
	endtask

	// Hold the sender until every mark is out, then let the pipeline settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_marks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, dim_t value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_THRESHOLD: thr_reg = value[THR_W-1:0];
			CFG_FRAME_WIDTH: begin
				width_reg = value;
				col_pos = 0;
				row_pos = 0;
				n_geometry++;
			end
			CFG_FRAME_HEIGHT: begin
				height_reg = value;
				col_pos = 0;
				row_pos = 0;
				n_geometry++;
			end
			default: ;
		endcase
	endtask

	task automatic set_geometry(int w, int h);
		write_reg(CFG_FRAME_WIDTH, dim_t'(w));
		write_reg(CFG_FRAME_HEIGHT, dim_t'(h));
	endtask

	function automatic pixel_t near_colour(pixel_t base, int spread);
		pixel_t p;
		int     v;
		if ($urandom_range(0, 9) == 0)
			return pixel_t'($urandom);
		for (int ch = 0; ch < N_CHAN; ch++) begin
			v = int'(base[ch*CHAN_W +: CHAN_W]) + int'($urandom_range(0, 2 * spread)) - spread;
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			p[ch*CHAN_W +: CHAN_W] = v[CHAN_W-1:0];
		end
		return p;
	endfunction

	// Full frame plus its W + 1 flush beats; mixed scatters the other kind in.
	task automatic send_frame(int w, int h, int spread, bit mixed);
		pixel_t base;
		case ($urandom_range(0, 5))
			0:       base = '0;
			1:       base = '1;
			default: base = pixel_t'($urandom);
		endcase
		for (int i = 0; i < w * h; i++) begin
			if (mixed && $urandom_range(0, 5) == 0)
				send_item(KIND_FLUSH, pixel_t'($urandom));
			else
				send_item(KIND_PIXEL, near_colour(base, spread));
		end
		for (int i = 0; i < w + 1; i++) begin
			if (mixed && $urandom_range(0, 5) == 0)
				send_item(KIND_PIXEL, pixel_t'($urandom));
			else
				send_flush(1);
		end
	endtask

	task automatic test_reset_defaults();
		pixel_t base;
		base = pixel_t'($urandom);
		gap_pct = 10;
		stall_pct = 10;
		// 640 wide by default: one row and a few pixels give the first marks
		for (int i = 0; i < 650; i++)
			send_item(KIND_PIXEL, near_colour(base, 8));
	endtask

	task automatic test_threshold_limits();
		pixel_t grid [9];
		gap_pct = 0;
		stall_pct = 0;
		set_geometry(3, 3);
		write_reg(CFG_THRESHOLD, 5);
		foreach (grid[i])
			grid[i] = 24'h808080;
		grid[1] = 24'h858080;	// red up by exactly the threshold
		grid[8] = 24'h80807A;	// blue down by one more
		foreach (grid[i])
			send_item(KIND_PIXEL, grid[i]);
		send_flush(4);
		write_reg(CFG_THRESHOLD, 0);
		foreach (grid[i])
			send_item(KIND_PIXEL, grid[i]);
		send_flush(4);
		foreach (grid[i])
			grid[i] = (i % 2) ? 24'hFFFFFF : 24'h000000;
		write_reg(CFG_THRESHOLD, 255);
		foreach (grid[i])
			send_item(KIND_PIXEL, grid[i]);
		send_flush(4);
		write_reg(CFG_THRESHOLD, 254);
		foreach (grid[i])
			send_item(KIND_PIXEL, grid[i]);
		send_flush(4);
	endtask

	task automatic test_small_frames();
		gap_pct = 20;
		stall_pct = 20;
		write_reg(CFG_THRESHOLD, 6);
		set_geometry(0, 0);
		send_item(KIND_PIXEL, pixel_t'($urandom));
		send_flush(2);
		set_geometry(1, 3);
		send_frame(1, 3, 8, 1'b0);
		set_geometry(3, 1);
		send_frame(3, 1, 8, 1'b0);
		set_geometry(2, 2);
		send_frame(2, 2, 8, 1'b0);
	endtask

	task automatic test_midframe_writes();
		pixel_t base;
		base = pixel_t'($urandom);
		gap_pct = 15;
		stall_pct = 15;
		set_geometry(4, 3);
		write_reg(CFG_THRESHOLD, 12);
		for (int i = 0; i < 7; i++)
			send_item(KIND_PIXEL, near_colour(base, 10));
		// threshold change mid-frame keeps the raster position
		write_reg(CFG_THRESHOLD, 3);
		for (int i = 0; i < 5; i++)
			send_item(KIND_PIXEL, near_colour(base, 10));
		send_flush(5);
		for (int i = 0; i < 6; i++)
			send_item(KIND_PIXEL, near_colour(base, 10));
		// geometry change abandons the partial frame
		write_reg(CFG_FRAME_HEIGHT, 2);
		send_frame(4, 2, 10, 1'b0);
		for (int i = 0; i < 5; i++)
			send_item(KIND_PIXEL, near_colour(base, 10));
		write_reg(CFG_FRAME_WIDTH, 3);
		send_frame(3, 2, 10, 1'b0);
	endtask

	task automatic test_spare_index();
		pixel_t base;
		base = pixel_t'($urandom);
		set_geometry(3, 2);
		for (int i = 0; i < 5; i++)
			send_item(KIND_PIXEL, near_colour(base, 9));
		write_reg(CFG_SPARE, 12'hFFF);
		// only the low byte reaches the threshold
		write_reg(CFG_THRESHOLD, 12'hF07);
		send_item(KIND_PIXEL, near_colour(base, 9));
		send_flush(4);
	endtask

	task automatic test_large_geometry();
		pixel_t base;
		base = pixel_t'($urandom);
		gap_pct = 5;
		stall_pct = 5;
		write_reg(CFG_THRESHOLD, 10);
		// oversized geometry clamps: a short burst closes no pixel
		set_geometry(4095, 4095);
		for (int i = 0; i < 40; i++)
			send_item(KIND_PIXEL, near_colour(base, 8));
		set_geometry(48, 2);
		send_frame(48, 2, 8, 1'b0);
	endtask

	task automatic test_random_frames();
		int   idle_levels [4] = '{0, 5, 20, 40};
		int   w;
		int   h;
		int   spread;
		int   shape;
		int   first_item;
		bit   need_geometry;
		dim_t thr;
		w = 4;
		h = 3;
		need_geometry = 1'b1;
		first_item = n_items;
		while (n_items - first_item < RANDOM_ITEMS) begin
			gap_pct = idle_levels[$urandom_range(0, 3)];
			stall_pct = idle_levels[$urandom_range(0, 3)];
			if (need_geometry || $urandom_range(0, 2) != 0) begin
				w = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
				h = $urandom_range(1, 6);
				set_geometry(w, h);
				need_geometry = 1'b0;
			end
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 7))
					0:       thr = 0;
					1:       thr = 255;
					2:       thr = dim_t'($urandom_range(0, 255));
					default: thr = dim_t'($urandom_range(0, 30));
				endcase
				write_reg(CFG_THRESHOLD, thr);
			end
			spread = $urandom_range(0, 24);
			shape = $urandom_range(0, 9);
			if (shape < 8) begin
				send_frame(w, h, spread, shape == 7);
			end else begin
				// broken sequence of random kinds; realign with a geometry write
				repeat ($urandom_range(1, w * h + w))
					send_item(logic'($urandom_range(0, 1)), pixel_t'($urandom));
				need_geometry = 1'b1;
			end
		end
	endtask

	task automatic test_back_to_back_frames();
		quiet = 1'b1;
		set_geometry(8, 4);
		write_reg(CFG_THRESHOLD, 8);
		send_frame(8, 4, 10, 1'b0);
		send_frame(8, 4, 10, 1'b1);
		send_frame(8, 4, 10, 1'b0);
	endtask

	initial begin
		foreach (win[i])
			win[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_threshold_limits();
		test_small_frames();
		test_midframe_writes();
		test_spare_index();
		test_large_geometry();
		test_random_frames();
		test_back_to_back_frames();
		wait_drained();
		$display("Sent %0d beats (%0d flush) over %0d geometry writes; checked %0d marks, %0d frames.",
			n_items, n_flush, n_geometry, n_checked, n_frames);
		$display("Thresholds 0 to 255, frames 1x1 up to 48 wide, oversized geometry, gaps and stalls.");
		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
